// ===== src/svm_pkg.sv =====
// Package for the stack machine decode/execute block.
// Holds sizes, opcodes, status codes and the result record; no dependencies.
package svm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_LOCALS  = 256;
  localparam int PC_BITS     = 16;

  localparam int SD_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int LA_W  = $clog2(MAX_LOCALS);
  localparam int LC_W  = 9;
  localparam int IN_W  = 48;
  localparam int OUT_W = 136;

  localparam logic [7:0] OP_CONST = 8'h41;
  localparam logic [7:0] OP_ADD   = 8'h6A;
  localparam logic [7:0] OP_SUB   = 8'h6B;
  localparam logic [7:0] OP_LGET  = 8'h20;
  localparam logic [7:0] OP_LSET  = 8'h21;
  localparam logic [7:0] OP_END   = 8'h0B;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALTED  = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_UNDER   = 3'd4,
    ST_RANGE   = 3'd5,
    ST_OVER    = 3'd6
  } status_t;

  // first member in the highest bits: status ends up at bit 0
  typedef struct packed {
    logic [31:0] steps_done;
    logic        halted_now;
    logic [31:0] moved_value;
    logic [31:0] top_value;
    logic [6:0]  depth_after;
    logic [6:0]  depth_before;
    logic [2:0]  instr_size;
    logic [15:0] instr_pc;
    status_t     status;
  } res_t;

endpackage

// ===== src/stack_vm_decode_execute.sv =====
// Stack machine decode/execute: one instruction per input transfer.
// Steps: registered read of the stack and locals RAMs on the input transfer, then
// execute and register the result; execute waits while the last result is not taken.
// A new instruction is not accepted until the previous one has executed: the registered
// read of the stack and locals RAMs is followed by the read-modify-write of the same RAMs.
// Reset: control state, pc, depth, step count cleared, local_count = 16; locals
// read as zero through per-entry valid bits, so no clearing pass is needed.
module stack_vm_decode_execute (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode_byte[7:0], imm_word[39:8], bytes_left[42:40], zero pad
  input  logic [svm_pkg::IN_W-1:0]  s_tdata,
  // mode[0]
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[2:0], instr_pc[18:3], instr_size[21:19], depth_before[28:22],
  // depth_after[35:29], top_value[67:36], moved_value[99:68], halted_now[100],
  // steps_done[132:101], zero pad
  output logic [svm_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [svm_pkg::LC_W-1:0]  cfg_wdata
);

  import svm_pkg::*;

  // architectural state
  logic [SD_W-1:0]       depth, depth_next;
  logic [PC_BITS-1:0]    pc, pc_next;
  logic                  halted, halted_next;
  logic [31:0]           steps, steps_next;
  logic [31:0]           top, top_next;
  logic [MAX_LOCALS-1:0] loc_valid;
  logic [LC_W-1:0]       local_count;

  // execute stage
  logic        b_valid;
  logic        b_mode;
  logic [7:0]  b_op;
  logic [31:0] b_imm;
  logic [2:0]  b_left;
  logic        loc_vq;
  logic        fire;
  logic        accept;

  res_t res;
  res_t res_next;

  // memory ports
  logic            stk_we;
  logic [SA_W-1:0] stk_waddr;
  logic [31:0]     stk_wdata;
  logic [SA_W-1:0] stk_raddr;
  logic [31:0]     stk_rdata;
  logic            loc_we;
  logic [LA_W-1:0] loc_waddr;
  logic [31:0]     loc_wdata;
  logic [LA_W-1:0] loc_raddr;
  logic [31:0]     loc_rdata;

  logic [SD_W-1:0] depth_m2;
  logic [LC_W-1:0] limit;
  logic            idx_bad;
  logic [2:0]      need;
  logic            known;
  logic [31:0]     lval;
  logic [31:0]     below;
  logic [31:0]     sum;
  status_t         status;
  logic [31:0]     moved;
  logic            halt_now;
  logic            clear_locals;

  assign s_tready = !b_valid;
  assign accept   = s_tvalid && s_tready;
  assign fire     = b_valid && (!m_tvalid || m_tready);
  assign m_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, res};

  assign depth_m2  = depth - SD_W'(2);
  assign stk_raddr = depth_m2[SA_W-1:0];
  assign loc_raddr = s_tdata[8 +: LA_W];

  svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we && fire),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  svm_ram #(.WIDTH(32), .DEPTH(MAX_LOCALS)) u_locals (
    .clk   (clk),
    .we    (loc_we && fire),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .re    (accept),
    .raddr (loc_raddr),
    .rdata (loc_rdata)
  );

  assign limit   = (local_count > LC_W'(MAX_LOCALS)) ? LC_W'(MAX_LOCALS) : local_count;
  assign idx_bad = {1'b0, b_imm[7:0]} >= limit;
  assign lval    = loc_vq ? loc_rdata : 32'd0;
  assign below   = (depth >= SD_W'(2)) ? stk_rdata : 32'd0;
  assign sum     = (b_op == OP_ADD) ? (stk_rdata + top) : (stk_rdata - top);

  always_comb begin
    known = 1'b1;
    need  = 3'd0;
    unique case (b_op) inside
      OP_CONST:                need = 3'd5;
      OP_LGET, OP_LSET:        need = 3'd2;
      OP_ADD, OP_SUB, OP_END:  need = 3'd1;
      default:                 known = 1'b0;
    endcase
  end

  always_comb begin
    status       = ST_OK;
    moved        = 32'd0;
    halt_now     = 1'b0;
    clear_locals = 1'b0;
    depth_next   = depth;
    pc_next      = pc;
    halted_next  = halted;
    steps_next   = steps;
    top_next     = top;
    stk_we       = 1'b0;
    stk_waddr    = depth[SA_W-1:0];
    stk_wdata    = b_imm;
    loc_we       = 1'b0;
    loc_waddr    = b_imm[LA_W-1:0];
    loc_wdata    = top;

    if (b_mode) begin
      depth_next   = '0;
      pc_next      = '0;
      halted_next  = 1'b0;
      steps_next   = 32'd0;
      top_next     = 32'd0;
      clear_locals = 1'b1;
    end else if (halted) begin
      status = ST_HALTED;
    end else if (b_left == 3'd0) begin
      status = ST_TRUNC;
    end else if (!known) begin
      status = ST_UNKNOWN;
    end else if (b_left < need) begin
      status = ST_TRUNC;
    end else begin
      unique case (b_op) inside
        OP_CONST: begin
          if (depth >= SD_W'(STACK_DEPTH)) begin
            status = ST_OVER;
          end else begin
            stk_we     = 1'b1;
            depth_next = depth + SD_W'(1);
            top_next   = b_imm;
            moved      = b_imm;
          end
        end
        OP_ADD, OP_SUB: begin
          if (depth < SD_W'(2)) begin
            status = ST_UNDER;
          end else begin
            stk_we     = 1'b1;
            stk_waddr  = depth_m2[SA_W-1:0];
            stk_wdata  = sum;
            depth_next = depth - SD_W'(1);
            top_next   = sum;
            moved      = sum;
          end
        end
        OP_LGET: begin
          if (idx_bad) begin
            status = ST_RANGE;
          end else if (depth >= SD_W'(STACK_DEPTH)) begin
            status = ST_OVER;
          end else begin
            stk_we     = 1'b1;
            stk_wdata  = lval;
            depth_next = depth + SD_W'(1);
            top_next   = lval;
            moved      = lval;
          end
        end
        OP_LSET: begin
          if (idx_bad) begin
            status = ST_RANGE;
          end else if (depth == '0) begin
            status = ST_UNDER;
          end else begin
            loc_we     = 1'b1;
            depth_next = depth - SD_W'(1);
            top_next   = below;
            moved      = top;
          end
        end
        default: begin
          halt_now    = 1'b1;
          halted_next = 1'b1;
        end
      endcase
    end

    if (!b_mode && status == ST_OK) begin
      pc_next    = pc + PC_BITS'(need);
      steps_next = steps + 32'd1;
    end

    res_next.status       = status;
    res_next.instr_pc     = b_mode ? 16'd0 : 16'(pc);
    res_next.instr_size   = (!b_mode && status == ST_OK) ? need : 3'd0;
    res_next.depth_before = 7'(depth);
    res_next.depth_after  = 7'(depth_next);
    res_next.top_value    = (depth_next == '0) ? 32'd0 : top_next;
    res_next.moved_value  = moved;
    res_next.halted_now   = halt_now;
    res_next.steps_done   = steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      depth       <= '0;
      pc          <= '0;
      halted      <= 1'b0;
      steps       <= 32'd0;
      top         <= 32'd0;
      loc_valid   <= '0;
      local_count <= LC_W'(16);
    end else begin
      if (cfg_we) begin
        local_count <= cfg_wdata;
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (fire) begin
        b_valid <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        depth  <= depth_next;
        pc     <= pc_next;
        halted <= halted_next;
        steps  <= steps_next;
        top    <= top_next;
        if (clear_locals) begin
          loc_valid <= '0;
        end else if (loc_we) begin
          loc_valid[loc_waddr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_mode <= s_tuser;
      b_op   <= s_tdata[7:0];
      b_imm  <= s_tdata[39:8];
      b_left <= s_tdata[42:40];
      loc_vq <= loc_valid[loc_raddr];
    end
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/svm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/stack_vm_decode_execute_tb.sv =====
// Testbench for stack_vm_decode_execute: directed and random instruction streams
// checked against a cycle-free model of the stack machine held in a scoreboard.
// Depends on svm_pkg (sizes, opcodes, status codes, result record) and the DUT.
module stack_vm_decode_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  class vm_scoreboard;
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] locals_mem [MAX_LOCALS];
    int unsigned depth;
    logic [PC_BITS-1:0] pc;
    bit halted;
    logic [31:0] steps;
    int unsigned local_count;
    res_t pending_results[$];
    int unsigned errors;

    function new();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      foreach (locals_mem[i]) locals_mem[i] = '0;
      depth = 0;
      pc = '0;
      halted = 0;
      steps = '0;
      local_count = 16;
      errors = 0;
    endfunction

    function void queue_result(status_t st, logic [15:0] at_pc, logic [2:0] size,
                               int unsigned depth_in, logic [31:0] moved, bit halt);
      res_t r;
      r.status       = st;
      r.instr_pc     = at_pc;
      r.instr_size   = size;
      r.depth_before = depth_in[6:0];
      r.depth_after  = depth[6:0];
      r.top_value    = (depth == 0) ? 32'd0 : stack_mem[depth-1];
      r.moved_value  = moved;
      r.halted_now   = halt;
      r.steps_done   = steps;
      pending_results.push_back(r);
    endfunction

    function void note_instruction(bit mode, logic [7:0] op, logic [31:0] imm,
                                   logic [2:0] left);
      int unsigned depth_in;
      int unsigned need;
      int unsigned limit;
      int unsigned idx;
      logic [31:0] moved;
      logic [31:0] a;
      logic [31:0] b;
      logic [15:0] at_pc;
      bit halt;
      status_t st;
      depth_in = depth;
      limit = (local_count > MAX_LOCALS) ? MAX_LOCALS : local_count;
      idx = imm[7:0];
      moved = '0;
      halt = 0;
      need = 0;
      st = ST_OK;
      if (mode) begin
        depth = 0;
        foreach (locals_mem[i]) locals_mem[i] = '0;
        pc = '0;
        halted = 0;
        steps = '0;
        queue_result(ST_OK, 16'd0, 3'd0, depth_in, 32'd0, 0);
        return;
      end
      if (halted) st = ST_HALTED;
      else if (left == 0) st = ST_TRUNC;
      else begin
        case (op) inside
          OP_CONST: need = 5;
          OP_LGET, OP_LSET: need = 2;
          OP_ADD, OP_SUB, OP_END: need = 1;
          default: st = ST_UNKNOWN;
        endcase
        if (st == ST_OK && left < need) st = ST_TRUNC;
        if (st == ST_OK) begin
          case (op) inside
            OP_CONST: if (depth >= STACK_DEPTH) st = ST_OVER;
            OP_ADD, OP_SUB: if (depth < 2) st = ST_UNDER;
            OP_LGET: begin
              if (idx >= limit) st = ST_RANGE;
              else if (depth >= STACK_DEPTH) st = ST_OVER;
            end
            OP_LSET: begin
              if (idx >= limit) st = ST_RANGE;
              else if (depth < 1) st = ST_UNDER;
            end
            default: ;
          endcase
        end
      end
      at_pc = 16'(pc);
      if (st != ST_OK) begin
        queue_result(st, at_pc, 3'd0, depth_in, 32'd0, 0);
        return;
      end
      case (op) inside
        OP_CONST: begin
          stack_mem[depth] = imm;
          depth++;
          moved = imm;
        end
        OP_ADD, OP_SUB: begin
          b = stack_mem[depth-1];
          a = stack_mem[depth-2];
          moved = (op == OP_ADD) ? a + b : a - b;
          depth--;
          stack_mem[depth-1] = moved;
        end
        OP_LGET: begin
          moved = locals_mem[idx];
          stack_mem[depth] = moved;
          depth++;
        end
        OP_LSET: begin
          depth--;
          moved = stack_mem[depth];
          locals_mem[idx] = moved;
        end
        default: begin
          halt = 1;
          halted = 1;
        end
      endcase
      pc = pc + PC_BITS'(need);
      steps++;
      queue_result(ST_OK, at_pc, 3'(need), depth_in, moved, halt);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("instr_pc", 32'(want.instr_pc), 32'(got.instr_pc));
      compare_field("instr_size", 32'(want.instr_size), 32'(got.instr_size));
      compare_field("depth_before", 32'(want.depth_before), 32'(got.depth_before));
      compare_field("depth_after", 32'(want.depth_after), 32'(got.depth_after));
      compare_field("top_value", want.top_value, got.top_value);
      compare_field("moved_value", want.moved_value, got.moved_value);
      compare_field("halted_now", 32'(want.halted_now), 32'(got.halted_now));
      compare_field("steps_done", want.steps_done, got.steps_done);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we;
  logic [LC_W-1:0]   cfg_wdata;

  vm_scoreboard sb;
  bit no_idle;
  int hold_req;
  int cycles;

  stack_vm_decode_execute i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls per transfer, plus one long hold on request
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(res_t'(m_tdata[$bits(res_t)-1:0]));
    end
  end

  task automatic send_item(bit mode, logic [7:0] op, logic [31:0] imm, logic [2:0] left);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{(IN_W-43){1'b0}}, left, imm, op};
    do @(posedge clk); while (!s_tready);
    sb.note_instruction(mode, op, imm, left);
  endtask

  task automatic exec(logic [7:0] op, logic [31:0] imm, logic [2:0] left);
    send_item(1'b0, op, imm, left);
  endtask

  task automatic load();
    send_item(1'b1, 8'($urandom), $urandom, 3'($urandom));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_local_count(logic [LC_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.local_count = value;
  endtask

  // one program: load, then a mostly well-formed instruction stream
  task automatic run_program(int len, bit push_heavy);
    int r;
    int unsigned lim;
    logic [7:0] op;
    logic [31:0] imm;
    logic [2:0] left;
    load();
    lim = (sb.local_count > MAX_LOCALS) ? MAX_LOCALS : sb.local_count;
    repeat (len) begin
      imm = $urandom;
      left = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd5;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        op = 8'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (push_heavy) begin
          if (r < 45) op = OP_CONST;
          else if (r < 75) op = OP_LGET;
          else if (r < 84) op = OP_ADD;
          else if (r < 92) op = OP_SUB;
          else if (r < 99) op = OP_LSET;
          else op = OP_END;
        end else begin
          if (r < 25) op = OP_CONST;
          else if (r < 40) op = OP_LGET;
          else if (r < 60) op = OP_ADD;
          else if (r < 80) op = OP_SUB;
          else if (r < 97) op = OP_LSET;
          else op = OP_END;
        end
        if ((op == OP_LGET || op == OP_LSET) && lim > 0 && $urandom_range(0, 9) != 0)
          imm[7:0] = 8'($urandom_range(0, lim - 1));
      end
      exec(op, imm, left);
    end
  endtask

  initial begin
    logic [LC_W-1:0] count_setting [8];
    int sent;
    int len;
    bit push_heavy;
    sb = new();
    cycles = 0;
    hold_req = 0;
    no_idle = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow, range ordering, wraparound, truncation, halt, load
    exec(OP_ADD, 32'd0, 3'd5);
    exec(OP_LSET, 32'h0000_0000, 3'd5);
    exec(OP_LSET, 32'h0000_0010, 3'd5);
    exec(OP_LGET, 32'h0000_000F, 3'd2);
    exec(OP_LGET, 32'h0000_0010, 3'd5);
    exec(OP_CONST, 32'h7FFF_FFFF, 3'd5);
    exec(OP_CONST, 32'h0000_0001, 3'd4);
    exec(OP_CONST, 32'h0000_0001, 3'd5);
    exec(OP_ADD, 32'hFFFF_FFFF, 3'd1);
    exec(OP_CONST, 32'hFFFF_FFFF, 3'd5);
    exec(OP_SUB, 32'd0, 3'd7);
    exec(OP_LSET, 32'h0000_000F, 3'd1);
    exec(OP_LSET, 32'hFFFF_FF0F, 3'd2);
    exec(OP_LGET, 32'h0000_000F, 3'd6);
    exec(8'hFF, 32'hFFFF_FFFF, 3'd5);
    exec(8'h00, 32'd0, 3'd0);
    exec(OP_CONST, 32'h0000_0000, 3'd7);
    exec(OP_END, 32'd0, 3'd1);
    exec(OP_CONST, 32'h1234_5678, 3'd5);
    load();
    exec(OP_LGET, 32'h0000_000F, 3'd5);
    exec(OP_END, 32'hFFFF_FFFF, 3'd6);
    load();

    count_setting = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd257, 9'd37, 9'd255, 9'd16};
    count_setting[7] = 9'($urandom_range(0, 511));
    for (int phase = 0; phase < 8; phase++) begin
      write_local_count(count_setting[phase]);
      no_idle = (phase % 3 == 1);
      if (phase == 1) hold_req = 80;
      sent = 0;
      while (sent < 95) begin
        push_heavy = ($urandom_range(0, 2) == 0);
        len = push_heavy ? $urandom_range(60, 150) : $urandom_range(5, 60);
        run_program(len, push_heavy);
        sent += len + 1;
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
